FILE: rtl/sinc_of_product_unit_top_macros.svh
// Assertion macros used by the sinc-of-product top level.
`ifndef SINC_OF_PRODUCT_UNIT_TOP_MACROS_SVH
`define SINC_OF_PRODUCT_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SINCP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sinc unit assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SINCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sinc unit assertion failed");

`endif

FILE: rtl/sincp_pkg.sv
// Types and constants of the sinc-of-product pipeline.
package sincp_pkg;

   localparam int X_W = 32;
   localparam int INV_W = 30;
   localparam int Y_W = 31;
   localparam int P_W = 31;
   localparam int S_W = 32;
   localparam int NUM_W = S_W + 7;
   localparam int OUT_W = 18;
   localparam int POLY_STEPS = 5;

   localparam logic [X_W-1:0] TAYLOR_LIMIT = 32'd1049;
   localparam logic [INV_W-1:0] INV_2PI_Q32 = 30'd683565276;
   localparam logic [Y_W-1:0] Q30_ONE = 31'h4000_0000;

   localparam logic [P_W-1:0] SIN_C11 = 31'd3864;
   // Horner coefficients in the order they are applied: C9, C7, C5, C3, C1.
   localparam logic [P_W-1:0] POLY_C [POLY_STEPS] = '{
      31'd172274, 31'd5026999, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd65536;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd16384;
   localparam logic [NUM_W-1:0] MAG_POS_MAX = 39'd65536;
   localparam logic [NUM_W-1:0] MAG_NEG_MAX = 39'd16384;

   // Registers from the input to the result: product, phase, square,
   // polynomial steps, sine, numerator, divider bits, output.
   localparam int LATENCY = 3 + POLY_STEPS + 2 + NUM_W + 1;

   typedef struct packed {
      logic neg;
      logic taylor;
   } sincp_tag_type;

endpackage

FILE: rtl/sinc_of_product_unit_top.sv
// Top level of the pipelined sin(x)/x unit for x = q * d.
//
// Usage: drive req_q_value (Q16) and req_distance (Q4) and raise start for
// one cycle per item. busy is always low, so an item is taken at every
// clock edge where start is high, one item per cycle sustained.
// Each item gives one result on rsp_sinc_value (signed Q16), marked by
// rsp_valid for exactly one cycle. The pipeline registers are the product,
// the range-reduction multiply, the square of the quarter-wave position,
// five polynomial multiply stages, the sine multiply, the numerator add,
// 39 one-bit divider stages and the output register.
// Products below 1049 (under 0.001) return exactly 1.0; for those the
// Taylor correction is far below one output step.
// Reset clears all valid bits, so items in flight are dropped.
// The receiver cannot stall: results are presented once and not held.
`include "sinc_of_product_unit_top_macros.svh"

module sinc_of_product_unit_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [15:0]                            req_q_value,
   input  logic [15:0]                            req_distance,
   output logic                                   rsp_valid,
   output logic signed [sincp_pkg::OUT_W-1:0]     rsp_sinc_value
);
   import sincp_pkg::*;

   // Stage 1: product.
   logic           v1_ff;
   logic [X_W-1:0] x1_ff, x1_in;

   // Stage 2: phase and quarter-wave fold.
   logic [61:0]    turns;
   logic [31:0]    phase;
   logic           v2_ff;
   logic [X_W-1:0] x2_ff;
   logic [Y_W-1:0] ya2_ff, ya2_in;
   sincp_tag_type  tag2_ff, tag2_in;

   // Stage 3 (index 0) and polynomial stages.
   logic [61:0]    ysq_full;
   logic           pv_ff   [POLY_STEPS+1];
   logic [X_W-1:0] px_ff   [POLY_STEPS+1];
   logic [Y_W-1:0] pya_ff  [POLY_STEPS+1];
   logic [Y_W-1:0] pysq_ff [POLY_STEPS+1];
   logic [P_W-1:0] pp_ff   [POLY_STEPS+1];
   sincp_tag_type  ptag_ff [POLY_STEPS+1];

   // Sine and numerator stages.
   logic [61:0]      s_full;
   logic             vs_ff;
   logic [S_W-1:0]   s_ff;
   logic [X_W-1:0]   xs_ff;
   sincp_tag_type    tags_ff;
   logic             vn_ff;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [X_W-1:0]   xn_ff;
   sincp_tag_type    tagn_ff;

   // Divider and output.
   logic              dv_valid;
   logic [NUM_W-1:0]  dv_quo;
   sincp_tag_type     dv_tag;
   logic              rsp_valid_ff;
   logic signed [OUT_W-1:0] res_ff, res_in;

   assign busy = 1'b0;

   assign x1_in = {16'b0, req_q_value} * {16'b0, req_distance};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
   end

   // Turns are Q52; the phase keeps 32 fraction bits of a turn.
   assign turns = 62'(x1_ff) * 62'(INV_2PI_Q32);
   assign phase = turns[51:20];

   always_comb begin
      ya2_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
      tag2_in.neg    = phase[31];
      tag2_in.taylor = (x1_ff < TAYLOR_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff   <= x1_ff;
      ya2_ff  <= ya2_in;
      tag2_ff <= tag2_in;
   end

   assign ysq_full = 62'(ya2_ff) * 62'(ya2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[0] <= 1'b0;
      end else begin
         pv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff[0]   <= x2_ff;
      pya_ff[0]  <= ya2_ff;
      pysq_ff[0] <= ysq_full[60:30];
      pp_ff[0]   <= SIN_C11;
      ptag_ff[0] <= tag2_ff;
   end

   for (genvar k = 1; k <= POLY_STEPS; k++) begin : g_poly
      logic [61:0] prod;
      logic [31:0] diff;

      assign prod = 62'(pp_ff[k-1]) * 62'(pysq_ff[k-1]);
      assign diff = 32'(POLY_C[k-1]) - prod[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[k] <= 1'b0;
         end else begin
            pv_ff[k] <= pv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         px_ff[k]   <= px_ff[k-1];
         pya_ff[k]  <= pya_ff[k-1];
         pysq_ff[k] <= pysq_ff[k-1];
         pp_ff[k]   <= diff[P_W-1:0];
         ptag_ff[k] <= ptag_ff[k-1];
      end
   end

   assign s_full = 62'(pp_ff[POLY_STEPS]) * 62'(pya_ff[POLY_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
         vn_ff <= 1'b0;
      end else begin
         vs_ff <= pv_ff[POLY_STEPS];
         vn_ff <= vs_ff;
      end
   end

   // Rounded divide: numerator is s * 64 + floor(x / 2).
   assign num_in = NUM_W'({s_ff, 6'b0}) + NUM_W'(xs_ff[X_W-1:1]);

   always_ff @(posedge clock) begin
      s_ff    <= s_full[61:30];
      xs_ff   <= px_ff[POLY_STEPS];
      tags_ff <= ptag_ff[POLY_STEPS];
      num_ff  <= num_in;
      xn_ff   <= xs_ff;
      tagn_ff <= tags_ff;
   end

   sincp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vn_ff),
      .in_num    (num_ff),
      .in_den    (xn_ff),
      .in_tag    (tagn_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   always_comb begin
      if (dv_tag.taylor) begin
         res_in = OUT_MAX;
      end else if (dv_tag.neg) begin
         res_in = (dv_quo > MAG_NEG_MAX) ? OUT_MIN : (OUT_W'(0) - OUT_W'(dv_quo));
      end else begin
         res_in = (dv_quo > MAG_POS_MAX) ? OUT_MAX : OUT_W'(dv_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sinc_value = res_ff;

   `SINCP_ASSERT_IMPL(a_latency, clock, reset, rsp_valid, $past(start, LATENCY))
   `SINCP_ASSERT_IMPL(a_zero_product, clock, reset, rsp_valid && $past(start && (req_q_value == 16'd0), LATENCY), rsp_sinc_value == OUT_MAX)
   `SINCP_ASSERT_IMPL(a_range, clock, reset, rsp_valid, (rsp_sinc_value <= OUT_MAX) && (rsp_sinc_value >= OUT_MIN))

endmodule

FILE: rtl/sincp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module sincp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [sincp_pkg::NUM_W-1:0]   in_num,
   input  logic [sincp_pkg::X_W-1:0]     in_den,
   input  sincp_pkg::sincp_tag_type      in_tag,
   output logic                          out_valid,
   output logic [sincp_pkg::NUM_W-1:0]   out_quo,
   output sincp_pkg::sincp_tag_type      out_tag
);
   import sincp_pkg::*;

   logic                 v_ff   [NUM_W];
   logic [X_W-1:0]       rem_ff [NUM_W];
   logic [NUM_W-1:0]     nq_ff  [NUM_W];
   logic [X_W-1:0]       den_ff [NUM_W];
   sincp_tag_type        tag_ff [NUM_W];

   logic                 src_v   [NUM_W];
   logic [X_W-1:0]       src_rem [NUM_W];
   logic [NUM_W-1:0]     src_nq  [NUM_W];
   logic [X_W-1:0]       src_den [NUM_W];
   sincp_tag_type        src_tag [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [X_W:0] trial;
      logic [X_W:0] diff;
      logic         ge;
      logic [X_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (i == 0) begin : g_first
         assign src_v[i]   = in_valid;
         assign src_rem[i] = '0;
         assign src_nq[i]  = in_num;
         assign src_den[i] = in_den;
         assign src_tag[i] = in_tag;
      end else begin : g_next
         assign src_v[i]   = v_ff[i-1];
         assign src_rem[i] = rem_ff[i-1];
         assign src_nq[i]  = nq_ff[i-1];
         assign src_den[i] = den_ff[i-1];
         assign src_tag[i] = tag_ff[i-1];
      end

      // The numerator shifts out at the top while quotient bits fill the bottom.
      assign trial  = {src_rem[i], src_nq[i][NUM_W-1]};
      assign diff   = trial - {1'b0, src_den[i]};
      assign ge     = (trial >= {1'b0, src_den[i]});
      assign rem_in = ge ? diff[X_W-1:0] : trial[X_W-1:0];
      assign nq_in  = {src_nq[i][NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= src_v[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         nq_ff[i]  <= nq_in;
         den_ff[i] <= src_den[i];
         tag_ff[i] <= src_tag[i];
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

FILE: sim/sinc_of_product_unit_checker.sv
// Checker for the sinc unit: predicts each accepted item's result and compares it.
module sinc_of_product_unit_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [15:0]                        req_q_value,
   input  logic [15:0]                        req_distance,
   input  logic                               rsp_valid,
   input  logic signed [sincp_pkg::OUT_W-1:0] rsp_sinc_value,
   output int                                 mismatch_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LIMIT_X = 64'd1049;
   localparam logic [63:0] TURN_SCALE = 64'd683565276;
   localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;

   logic signed [sincp_pkg::OUT_W-1:0] sinc_expected_q[$];

   // Odd polynomial sine over a quarter wave, Q30 in and out.
   function automatic logic [63:0] quarter_wave_sine(logic [63:0] y);
      logic [63:0] y2;
      logic [63:0] acc;
      y2 = (y * y) >> 30;
      acc = 64'd172274 - ((64'd3864 * y2) >> 30);
      acc = 64'd5026999 - ((acc * y2) >> 30);
      acc = 64'd85569306 - ((acc * y2) >> 30);
      acc = 64'd693598668 - ((acc * y2) >> 30);
      acc = 64'd1686629713 - ((acc * y2) >> 30);
      return (acc * y) >> 30;
   endfunction

   function automatic logic signed [sincp_pkg::OUT_W-1:0] predict_sinc(
         logic [15:0] q, logic [15:0] d);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] x4;
      logic [63:0] phase;
      logic [63:0] frac;
      logic [63:0] y;
      logic [63:0] mag;
      logic [1:0]  quad;
      longint      res;
      x = {48'd0, q} * {48'd0, d};
      if (x < LIMIT_X) begin
         x2 = x * x;
         x4 = (x2 * x2) >> 40;
         res = longint'((((64'd1 << 40) - x2 / 6 + x4 / 120) + (64'd1 << 23)) >> 24);
      end else begin
         phase = ((x * TURN_SCALE) >> 20) & 64'hFFFF_FFFF;
         quad = phase[31:30];
         frac = phase & (UNIT_Q30 - 1);
         y = quad[0] ? (UNIT_Q30 - frac) : frac;
         mag = (quarter_wave_sine(y) * 64 + x / 2) / x;
         res = quad[1] ? -longint'(mag) : longint'(mag);
      end
      if (res > 65536) res = 65536;
      if (res < -16384) res = -16384;
      return res[sincp_pkg::OUT_W-1:0];
   endfunction

   assign pending_count = sinc_expected_q.size();

   always @(posedge clock) begin
      logic signed [sincp_pkg::OUT_W-1:0] want;
      if (reset) begin
         mismatch_count <= 0;
      end else begin
         if (start && !busy)
            sinc_expected_q.push_back(predict_sinc(req_q_value, req_distance));
         if (rsp_valid) begin
            if (sinc_expected_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result %0d with no item pending", rsp_sinc_value);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = sinc_expected_q.pop_front();
               if (want !== rsp_sinc_value) begin
                  if (mismatch_count < 10)
                     $display("sinc_value mismatch: expected %0d, got %0d",
                              want, rsp_sinc_value);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: sim/sinc_of_product_unit_top_tb.sv
// Top of the sinc unit testbench: clock, reset, stimulus and verdict.
module sinc_of_product_unit_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_q_value = '0;
   logic [15:0] req_distance = '0;
   logic        rsp_valid;
   logic signed [sincp_pkg::OUT_W-1:0] rsp_sinc_value;
   int          mismatch_count;
   int          pending_count;

   always #2 clock = ~clock;

   sinc_of_product_unit_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_q_value(req_q_value), .req_distance(req_distance),
      .rsp_valid(rsp_valid), .rsp_sinc_value(rsp_sinc_value)
   );

   sinc_of_product_unit_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_q_value(req_q_value), .req_distance(req_distance),
      .rsp_valid(rsp_valid), .rsp_sinc_value(rsp_sinc_value),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // Issues one item, with a random idle burst ahead of it when allowed.
   task automatic issue_item(logic [15:0] q, logic [15:0] d, bit allow_gaps);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      start <= 1'b1;
      req_q_value <= q;
      req_distance <= d;
      @(posedge clock iff !busy);
   endtask

   initial begin
      logic [15:0] q;
      logic [15:0] d;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners: zero product, full scale, the Taylor boundary, tiny products.
      issue_item(16'd0, 16'd0, 1'b1);
      issue_item(16'hFFFF, 16'hFFFF, 1'b1);
      issue_item(16'd0, 16'hFFFF, 1'b1);
      issue_item(16'hFFFF, 16'd0, 1'b1);
      issue_item(16'd1, 16'd1, 1'b1);
      issue_item(16'd1, 16'd1048, 1'b1);
      issue_item(16'd1, 16'd1049, 1'b1);
      issue_item(16'd1049, 16'd1, 1'b1);
      issue_item(16'd1048, 16'd1, 1'b1);
      issue_item(16'd32, 16'd33, 1'b1);
      issue_item(16'hAAAA, 16'h5555, 1'b1);
      issue_item(16'h5555, 16'hAAAA, 1'b1);
      issue_item(16'h8000, 16'h0010, 1'b1);
      issue_item(16'h8000, 16'hFFF0, 1'b1);
      issue_item(16'h1000, 16'h1000, 1'b1);
      issue_item(16'd1024, 16'd1024, 1'b1);

      for (int i = 0; i < 600; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               // Around the Taylor threshold.
               q = 16'($urandom_range(0, 64));
               d = 16'($urandom_range(0, 64));
            end
            1: begin
               q = 16'($urandom_range(0, 255));
               d = 16'($urandom);
            end
            default: begin
               q = 16'($urandom);
               d = 16'($urandom);
            end
         endcase
         issue_item(q, d, i < 480);
      end
      start <= 1'b0;

      wait (pending_count == 0);
      repeat (sincp_pkg::LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/sincp_pkg.sv
rtl/sincp_div.sv
rtl/sinc_of_product_unit_top.sv
sim/sinc_of_product_unit_checker.sv
sim/sinc_of_product_unit_top_tb.sv
